// File: sv/imu_zero_offset_calibrator_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the IMU zero-offset calibrator.
// Each macro expands to a clocked concurrent assertion in simulation and
// to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef IMU_ZERO_OFFSET_CALIBRATOR_DEFINES_SVH
`define IMU_ZERO_OFFSET_CALIBRATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of clk, switched off while rst is high.
`define IZOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define IZOC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IZOC_ASSERT(lbl, prop, msg)
`define IZOC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: sv/izoc_pkg.sv
// ---------------------------------------------------------------------------
// IMU zero-offset calibrator package
// Word types, calibration phase and divider state codes, register map and reset values.
// ---------------------------------------------------------------------------
package izoc_pkg;

  typedef struct packed {
    logic signed [15:0] raw_accel_x;
    logic signed [15:0] raw_accel_y;
    logic signed [15:0] raw_accel_z;
    logic signed [15:0] raw_gyro_x;
    logic signed [15:0] raw_gyro_y;
    logic signed [15:0] raw_gyro_z;
  } sample_word_t;

  typedef struct packed {
    logic signed [15:0] corrected_accel_x;
    logic signed [15:0] corrected_accel_y;
    logic signed [15:0] corrected_accel_z;
    logic signed [15:0] corrected_gyro_x;
    logic signed [15:0] corrected_gyro_y;
    logic signed [15:0] corrected_gyro_z;
    logic [1:0]         phase;
  } result_word_t;

  typedef enum logic [1:0] {
    PH_REFERENCE  = 2'd0,
    PH_WAIT_STILL = 2'd1,
    PH_AVERAGING  = 2'd2,
    PH_CALIBRATED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    DIV_IDLE  = 2'd0,
    DIV_MUL   = 2'd1,
    DIV_WRITE = 2'd2
  } div_state_t;

  localparam int AXES     = 6;
  localparam int ACC_AXES = 3;
  localparam int AXIS_Z   = 2;

  // Register indexes (word address bits [3:2]).
  localparam logic [1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [1:0] CFG_RUN_LENGTH = 2'd1;
  localparam logic [1:0] CFG_GRAVITY    = 2'd2;

  localparam logic [15:0]        THRESHOLD_RESET  = 16'd200;
  localparam logic [7:0]         RUN_LENGTH_RESET = 8'd100;
  localparam logic signed [15:0] GRAVITY_RESET    = 16'sd16056;

endpackage

// File: sv/imu_zero_offset_calibrator.sv
// ---------------------------------------------------------------------------
// IMU zero-offset calibrator
// Path: an accepted sample word passes the input stage and output registers.
// Throughput: one word per cycle, set by the single processing stage, while
// the receiver does not stall; the divider pauses it after averaging ends.
// Reset: synchronous; registers return to their defaults, phase to reference.
// ---------------------------------------------------------------------------
`include "imu_zero_offset_calibrator_defines.svh"

// Datapath overview.
//
// A sample word is first captured in the input stage register. From there a
// single layer of logic corrects the six axes by the current offsets and
// works out the next calibration state, and the result word is captured in
// the output register while the state registers update in the same edge.
// The input stage can take a new word while a finished result still waits
// in the output register, so the block keeps streaming under short stalls.
//
// Calibration runs through four phases. The first sample is stored as the
// stillness reference. While waiting for stillness, each sample is compared
// axis by axis with the previous accel sample; a still run grows while every
// change stays strictly below the threshold and restarts otherwise. When the
// run is long enough the next AVERAGE_SAMPLES samples are accumulated, with
// the gravity reference taken off accel z. The word that completes the sum
// starts the offset divider, which multiplies in DIV_MUL and writes the six
// offsets in DIV_WRITE; the input stage holds its next word while it is busy
// so that every word after the last averaging word sees the new offsets.
//
// Configuration registers sit on a small APB-style port at byte addresses
// 0 (threshold), 4 (run length) and 8 (gravity reference), decoded from
// paddr[3:2] only; writes to address 12 are ignored and it reads as zero.
module imu_zero_offset_calibrator
  import izoc_pkg::*;
#(
  parameter int AVERAGE_SAMPLES = 100
) (
  input  logic         clk,
  input  logic         rst,

  input  logic         sample_valid,
  output logic         sample_stall,
  input  sample_word_t sample,

  output logic         result_valid,
  input  logic         result_stall,
  output result_word_t result,

  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // The averaging counter must hold AVERAGE_SAMPLES itself; each sum must
  // hold that many terms of up to 17 signed bits.
  localparam int CNT_W = $clog2(AVERAGE_SAMPLES + 1);
  localparam int SUM_W = 17 + CNT_W;
  localparam logic [CNT_W-1:0] AVG_COUNT = CNT_W'(AVERAGE_SAMPLES);

  // Configuration registers.
  logic [15:0]        fluctuation_threshold;
  logic [7:0]         still_run_length;
  logic signed [15:0] gravity_reference;
  logic               cfg_write;

  // Pipeline control.
  logic         stage_valid;
  sample_word_t stage;
  logic         sample_accept;
  logic         stage_advance;
  logic         div_busy;
  logic         div_start;

  // Calibration state.
  phase_t             phase, phase_next;
  logic signed [15:0] previous_accel [ACC_AXES];
  logic [7:0]         still_counter, still_counter_next;
  logic [CNT_W-1:0]   average_counter, average_counter_next;
  logic signed [SUM_W-1:0] axis_sums [AXES];
  logic signed [SUM_W-1:0] sum_next  [AXES];
  logic [15:0]        axis_offsets [AXES];
  logic               prev_update;
  logic               sums_update;
  logic               avg_done;

  // Per-item datapath.
  logic signed [15:0] raw         [AXES];
  logic signed [15:0] corrected   [AXES];
  logic signed [16:0] accel_diff  [ACC_AXES];
  logic [16:0]        accel_mag   [ACC_AXES];
  logic signed [16:0] avg_term    [AXES];
  logic               still;
  logic [7:0]         still_inc;
  logic [CNT_W-1:0]   avg_inc;
  logic               avg_last;
  result_word_t       stage_result;

  // -------------------------------------------------------------------------
  // Configuration port. Every access completes in its access cycle.
  // -------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fluctuation_threshold <= THRESHOLD_RESET;
      still_run_length      <= RUN_LENGTH_RESET;
      gravity_reference     <= GRAVITY_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        CFG_THRESHOLD:  fluctuation_threshold <= pwdata[15:0];
        CFG_RUN_LENGTH: still_run_length      <= pwdata[7:0];
        CFG_GRAVITY:    gravity_reference     <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      CFG_THRESHOLD:  prdata = {16'd0, fluctuation_threshold};
      CFG_RUN_LENGTH: prdata = {24'd0, still_run_length};
      CFG_GRAVITY:    prdata = {16'd0, gravity_reference};
      default:        prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Handshake. The stage word moves on when the output register is empty or
  // being emptied, unless the divider is still producing offsets.
  // -------------------------------------------------------------------------
  assign stage_advance = stage_valid && (!result_valid || !result_stall) && !div_busy;
  assign sample_stall  = stage_valid && !stage_advance;
  assign sample_accept = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_accept) begin
      stage_valid <= 1'b1;
    end else if (stage_advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_accept) begin
      stage <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stage_advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance) begin
      result <= stage_result;
    end
  end

  // -------------------------------------------------------------------------
  // Per-item datapath.
  // -------------------------------------------------------------------------
  assign raw[0] = stage.raw_accel_x;
  assign raw[1] = stage.raw_accel_y;
  assign raw[2] = stage.raw_accel_z;
  assign raw[3] = stage.raw_gyro_x;
  assign raw[4] = stage.raw_gyro_y;
  assign raw[5] = stage.raw_gyro_z;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      corrected[i] = raw[i] - axis_offsets[i];
    end
  end

  assign stage_result.corrected_accel_x = corrected[0];
  assign stage_result.corrected_accel_y = corrected[1];
  assign stage_result.corrected_accel_z = corrected[2];
  assign stage_result.corrected_gyro_x  = corrected[3];
  assign stage_result.corrected_gyro_y  = corrected[4];
  assign stage_result.corrected_gyro_z  = corrected[5];
  assign stage_result.phase             = phase;

  // Stillness test: the change on each accel axis, as a 17-bit magnitude,
  // must stay strictly below the threshold.
  always_comb begin
    still = 1'b1;
    for (int i = 0; i < ACC_AXES; i++) begin
      accel_diff[i] = 17'(raw[i]) - 17'(previous_accel[i]);
      accel_mag[i]  = accel_diff[i][16] ? 17'(-accel_diff[i]) : 17'(accel_diff[i]);
      if (accel_mag[i] >= {1'b0, fluctuation_threshold}) begin
        still = 1'b0;
      end
    end
  end

  assign still_inc = still_counter + 8'd1;

  // Averaging terms; gravity comes off the z accel axis only.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      if (i == AXIS_Z) begin
        avg_term[i] = 17'(raw[i]) - 17'(gravity_reference);
      end else begin
        avg_term[i] = 17'(raw[i]);
      end
      sum_next[i] = axis_sums[i] + SUM_W'(avg_term[i]);
    end
  end

  assign avg_inc  = average_counter + 1'b1;
  assign avg_last = (avg_inc >= AVG_COUNT);

  // Next calibration state for the word in the stage register.
  always_comb begin
    phase_next           = phase;
    still_counter_next   = still_counter;
    average_counter_next = average_counter;
    prev_update          = 1'b0;
    sums_update          = 1'b0;
    avg_done             = 1'b0;
    unique case (phase)
      PH_REFERENCE: begin
        prev_update = 1'b1;
        phase_next  = PH_WAIT_STILL;
      end
      PH_WAIT_STILL: begin
        prev_update = 1'b1;
        if (still) begin
          if (still_inc >= still_run_length) begin
            still_counter_next = '0;
            phase_next         = PH_AVERAGING;
          end else begin
            still_counter_next = still_inc;
          end
        end else begin
          still_counter_next = '0;
        end
      end
      PH_AVERAGING: begin
        sums_update          = 1'b1;
        average_counter_next = avg_inc;
        if (avg_last) begin
          avg_done   = 1'b1;
          phase_next = PH_CALIBRATED;
        end
      end
      PH_CALIBRATED: begin
      end
    endcase
  end

  assign div_start = stage_advance && avg_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_REFERENCE;
      still_counter   <= '0;
      average_counter <= '0;
      for (int i = 0; i < ACC_AXES; i++) begin
        previous_accel[i] <= '0;
      end
      for (int i = 0; i < AXES; i++) begin
        axis_sums[i] <= '0;
      end
    end else if (stage_advance) begin
      phase           <= phase_next;
      still_counter   <= still_counter_next;
      average_counter <= average_counter_next;
      if (prev_update) begin
        for (int i = 0; i < ACC_AXES; i++) begin
          previous_accel[i] <= raw[i];
        end
      end
      if (sums_update) begin
        for (int i = 0; i < AXES; i++) begin
          axis_sums[i] <= sum_next[i];
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Offset divider. It reads the sums from the edge after the last averaging
  // word, when they are final.
  // -------------------------------------------------------------------------
  izoc_offset_divider #(
    .DIVISOR (AVERAGE_SAMPLES),
    .SUM_W   (SUM_W)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .sums    (axis_sums),
    .busy    (div_busy),
    .offsets (axis_offsets)
  );

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `IZOC_ASSERT(a_div_after_average, div_start |=> div_busy && phase == PH_CALIBRATED, "divider did not start at end of averaging")
  `IZOC_ASSERT(a_busy_only_calibrated, div_busy |-> phase == PH_CALIBRATED, "divider busy outside calibrated phase")
  `IZOC_ASSERT(a_calibrated_sticks, phase == PH_CALIBRATED |=> phase == PH_CALIBRATED, "left calibrated phase")
  `IZOC_ASSERT_ALWAYS(a_reset_clears, rst |=> !result_valid && !stage_valid && !div_busy, "reset left pipeline busy")

endmodule

// File: sv/izoc_offset_divider.sv
// ---------------------------------------------------------------------------
// IMU zero-offset calibrator: offset divider
// Divides six signed sums by a constant sample count, truncating toward zero,
// through a reciprocal multiply, and holds the resulting 16-bit offsets.
// ---------------------------------------------------------------------------
module izoc_offset_divider
  import izoc_pkg::*;
#(
  parameter int DIVISOR = 100,
  parameter int SUM_W   = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sums [AXES],
  output logic                    busy,
  output logic [15:0]             offsets [AXES]
);

  // With RECIP = ceil(2^(SUM_W+L) / DIVISOR) and 2^L >= DIVISOR the
  // quotient floor(n / DIVISOR) is exact for every n below 2^SUM_W.
  localparam int L         = $clog2(DIVISOR);
  localparam int DIV_SHIFT = SUM_W + L;
  localparam int RECIP_W   = SUM_W + 2;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR);

  div_state_t state, state_next;
  logic       mul_en;
  logic       wr_en;

  logic [SUM_W-1:0]  mag  [AXES];
  logic [PROD_W-1:0] prod [AXES];
  logic              neg  [AXES];
  logic [15:0]       quot [AXES];

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE:  if (start) state_next = DIV_MUL;
      DIV_MUL:   state_next = DIV_WRITE;
      DIV_WRITE: state_next = DIV_IDLE;
      default:   state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state != DIV_IDLE);
    mul_en = (state == DIV_MUL);
    wr_en  = (state == DIV_WRITE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      mag[i]  = sums[i][SUM_W-1] ? (~sums[i] + 1'b1) : sums[i];
      quot[i] = prod[i][DIV_SHIFT +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      for (int i = 0; i < AXES; i++) begin
        prod[i] <= PROD_W'(mag[i]) * PROD_W'(RECIP);
        neg[i]  <= sums[i][SUM_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        offsets[i] <= '0;
      end
    end else if (wr_en) begin
      for (int i = 0; i < AXES; i++) begin
        offsets[i] <= neg[i] ? (~quot[i] + 1'b1) : quot[i];
      end
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// IMU zero-offset calibrator testbench
// Drives six-axis sample words through the calibrator and predicts every
// corrected word, including the phase code, from its own copy of the
// calibration state. Covers register access, the stillness search under many
// settings, averaging, and the calibrated phase, with random idling on both
// sides and long receiver hold-offs.
// ---------------------------------------------------------------------------
module tb_top;
  import izoc_pkg::*;

  // Must match the averaging window that the block is built with.
  localparam int AVG_WINDOW     = 100;
  // Long receiver hold-off, long enough to back the block up into its input.
  localparam int LONG_HOLD      = 100;
  // Settling time after the last result word, with margin over the pipeline
  // latency and the divider pause.
  localparam int DRAIN_CYCLES   = 8;
  // Cycles without any handshake before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;
  // Register index beyond the map; writes there must be ignored.
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;

  typedef enum {SAMPLE_NOISE, SAMPLE_STILL, SAMPLE_BREAK, SAMPLE_REST} sample_kind_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         sample_valid = 1'b0;
  logic         sample_stall;
  sample_word_t sample_data = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_word_t result_data;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  // Predicted configuration registers.
  logic [15:0]        still_threshold = THRESHOLD_RESET;
  logic [7:0]         still_run_needed = RUN_LENGTH_RESET;
  logic signed [15:0] gravity_z = GRAVITY_RESET;

  // Predicted calibration state.
  int           prev_acc [ACC_AXES] = '{default: 0};
  logic [7:0]   still_count = '0;
  phase_t       cal_phase = PH_REFERENCE;
  logic [6:0]   avg_count = '0;
  int           axis_sum [AXES] = '{default: 0};
  logic [15:0]  axis_offset [AXES] = '{default: '0};

  // Per-axis centre of the samples sent while averaging.
  int           rest_base [AXES] = '{default: 0};

  // Corrected words still owed by the block, oldest first.
  result_word_t corrected_words_due [$];

  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  sender_steady = 1'b0;
  bit  receiver_steady = 1'b0;
  int  hold_requests = 0;
  int  holds_served = 0;
  int  stall_left = 0;

  imu_zero_offset_calibrator #(
    .AVERAGE_SAMPLES(AVG_WINDOW)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Axis i of a six-axis word, accel x first.
  function automatic logic [15:0] axis_of(logic [95:0] bits, int i);
    return bits[95 - 16 * i -: 16];
  endfunction

  function automatic logic [15:0] clamp16(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // A sample is still when every accel axis moved strictly less than the
  // threshold since the previous sample. A zero threshold never passes.
  function automatic bit sample_is_still(sample_word_t word);
    logic [95:0] bits;
    int diff;
    bits = word;
    for (int i = 0; i < ACC_AXES; i++) begin
      diff = $signed(axis_of(bits, i));
      diff = diff - prev_acc[i];
      if (diff < 0) diff = -diff;
      if (diff >= int'(still_threshold)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Works out the corrected word for one accepted sample and advances the
  // calibration state. The output always uses the offsets as they stood
  // before this sample, so the word that completes the average still comes
  // out with zero offsets.
  function automatic result_word_t calibrator_step(sample_word_t word);
    logic [95:0] bits;
    logic [95:0] corrected;
    logic [7:0]  next_count;
    result_word_t predicted;
    int a;
    int q;
    bit still;
    bits = word;
    for (int i = 0; i < AXES; i++)
      corrected[95 - 16 * i -: 16] = axis_of(bits, i) - axis_offset[i];
    predicted = {corrected, cal_phase};
    case (cal_phase)
      PH_REFERENCE: begin
        for (int i = 0; i < ACC_AXES; i++) prev_acc[i] = $signed(axis_of(bits, i));
        cal_phase = PH_WAIT_STILL;
      end
      PH_WAIT_STILL: begin
        still = sample_is_still(word);
        for (int i = 0; i < ACC_AXES; i++) prev_acc[i] = $signed(axis_of(bits, i));
        if (still) begin
          // A run length of zero behaves like one, since the count is
          // compared after it has been bumped.
          next_count = still_count + 8'd1;
          still_count = next_count;
          if (next_count >= still_run_needed) begin
            still_count = '0;
            cal_phase = PH_AVERAGING;
          end
        end else begin
          still_count = '0;
        end
      end
      PH_AVERAGING: begin
        for (int i = 0; i < AXES; i++) begin
          a = $signed(axis_of(bits, i));
          if (i == AXIS_Z) a = a - gravity_z;
          axis_sum[i] = axis_sum[i] + a;
        end
        avg_count = avg_count + 7'd1;
        if (avg_count >= AVG_WINDOW) begin
          // Division truncates toward zero, then wraps to 16 bits.
          for (int i = 0; i < AXES; i++) begin
            q = axis_sum[i] / AVG_WINDOW;
            axis_offset[i] = q[15:0];
          end
          cal_phase = PH_CALIBRATED;
        end
      end
      default: ;
    endcase
    return predicted;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus shaping
  // ---------------------------------------------------------------------------

  // Still samples stay within the threshold on every accel axis, break
  // samples throw accel x to the far extreme, rest samples scatter around
  // the per-axis centre. Gyro axes are random unless resting.
  function automatic sample_word_t make_sample(sample_kind_t kind);
    logic [95:0] bits;
    int lim;
    bits = {$urandom, $urandom, $urandom};
    lim = (still_threshold == 0) ? 0 : int'(still_threshold) - 1;
    for (int i = 0; i < AXES; i++) begin
      if (kind == SAMPLE_STILL && i < ACC_AXES)
        bits[95 - 16 * i -: 16] = clamp16(prev_acc[i] + int'($urandom_range(0, 2 * lim)) - lim);
      else if (kind == SAMPLE_REST)
        bits[95 - 16 * i -: 16] = clamp16(rest_base[i] + int'($urandom_range(0, 1000)) - 500);
    end
    if (kind == SAMPLE_BREAK)
      bits[95 -: 16] = (prev_acc[0] < 0) ? 16'h7FFF : 16'h8000;
    return bits;
  endfunction

  // Keeps the block in the stillness search: a sample that would complete
  // the run is swapped for a break. The break moves accel x by at least
  // 32768, so it works for any threshold up to that.
  function automatic sample_word_t keep_waiting(sample_word_t word);
    logic [7:0] next_count;
    next_count = still_count + 8'd1;
    if (cal_phase == PH_WAIT_STILL && sample_is_still(word) &&
        next_count >= still_run_needed)
      return make_sample(SAMPLE_BREAK);
    return word;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample side
  // ---------------------------------------------------------------------------

  // Offers one word after a random gap and waits until it is taken. Valid
  // is only lowered when a gap follows, so back-to-back words never see
  // valid dropped and raised in the same step.
  task automatic send_sample(input sample_word_t word);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_data  <= word;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    corrected_words_due.push_back(calibrator_step(word));
  endtask

  // Stops offering and waits until every owed word is back, then lets the
  // block settle before anything else happens.
  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (corrected_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      CFG_THRESHOLD:  still_threshold = value[15:0];
      CFG_RUN_LENGTH: still_run_needed = value[7:0];
      CFG_GRAVITY:    gravity_z = value[15:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_register(input logic [1:0] index, output logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {index, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reads back all three registers; only the bits a register holds count.
  task automatic check_registers();
    logic [31:0] got;
    read_register(CFG_THRESHOLD, got);
    if (got[15:0] !== still_threshold) begin
      $display("%0t: threshold register: expected %0d, got %0d",
               $time, still_threshold, got[15:0]);
      fail_count++;
    end
    read_register(CFG_RUN_LENGTH, got);
    if (got[7:0] !== still_run_needed) begin
      $display("%0t: run length register: expected %0d, got %0d",
               $time, still_run_needed, got[7:0]);
      fail_count++;
    end
    read_register(CFG_GRAVITY, got);
    if (got[15:0] !== gravity_z) begin
      $display("%0t: gravity register: expected %0d, got %0d",
               $time, gravity_z, $signed(got[15:0]));
      fail_count++;
    end
  endtask

  // Settings only change while the block is idle.
  task automatic set_calibration_registers(input logic [15:0] threshold,
                                           input logic [7:0] run_length,
                                           input logic signed [15:0] gravity);
    wait_drained();
    write_register(CFG_THRESHOLD, {16'd0, threshold});
    write_register(CFG_RUN_LENGTH, {24'd0, run_length});
    write_register(CFG_GRAVITY, {{16{gravity[15]}}, gravity});
    check_registers();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: checking and receiver stalls
  // ---------------------------------------------------------------------------

  function automatic void compare_result(result_word_t want, result_word_t got);
    logic [97:0] w;
    logic [97:0] g;
    w = want;
    g = got;
    for (int i = 0; i < AXES; i++) begin
      if (w[97 - 16 * i -: 16] !== g[97 - 16 * i -: 16]) begin
        $display("%0t: corrected axis %0d: expected %0d, got %0d", $time, i,
                 $signed(w[97 - 16 * i -: 16]), $signed(g[97 - 16 * i -: 16]));
        fail_count++;
      end
    end
    if (want.phase !== got.phase) begin
      $display("%0t: phase: expected %0d, got %0d", $time, want.phase, got.phase);
      fail_count++;
    end
  endfunction

  // Every accepted word is checked against the oldest owed one. After each
  // accepted word the receiver draws how long it stalls; a long hold-off
  // request overrides that and is counted down here, cycle by cycle.
  always @(posedge clk) begin : result_receiver
    if (!rst && result_valid && !result_stall) begin
      if (corrected_words_due.size() == 0) begin
        $display("%0t: unexpected result word: expected none, got %h", $time, result_data);
        fail_count++;
      end else begin
        compare_result(corrected_words_due.pop_front(), result_data);
      end
    end
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      stall_left = LONG_HOLD;
    end else if (result_valid && !result_stall) begin
      stall_left = receiver_steady ? 0 : $urandom_range(0, 16);
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end
    result_stall <= (stall_left > 0);
  end

  // Any handshake on either channel or the register port counts as progress.
  always @(posedge clk) begin : watchdog
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_register_defaults();
    check_registers();
  endtask

  // With a zero threshold nothing counts as still, not even a repeated
  // sample. The corner words also make every input bit take both values and
  // show that corrected words equal raw words before calibration. A write
  // beyond the register map must leave all three registers untouched.
  task automatic test_zero_threshold();
    logic [95:0] corner_words [9];
    corner_words = '{{6{16'h7FFF}}, {6{16'h8000}}, {6{16'h8000}}, 96'd0,
                     {6{16'h5555}}, {6{16'hAAAA}}, {3{16'h7FFF, 16'h8000}},
                     {3{16'h8000, 16'h7FFF}}, {3{16'h0001, 16'hFFFF}}};
    sender_steady = 1'b1;
    receiver_steady <= 1'b1;
    write_register(CFG_THRESHOLD, 32'd0);
    write_register(CFG_UNMAPPED, 32'h0000_1234);
    check_registers();
    for (int k = 0; k < 9; k++) send_sample(corner_words[k]);
  endtask

  // Widest threshold: a full-scale swing of 65535 breaks the run, one step
  // less still counts as still.
  task automatic test_widest_threshold();
    logic [15:0] x_steps [8];
    x_steps = '{16'h8000, 16'h7FFF, 16'h8001, 16'h7FFF,
                16'h8000, 16'h7FFE, 16'h8000, 16'h0000};
    set_calibration_registers(16'hFFFF, 8'd255, GRAVITY_RESET);
    sender_steady = 1'b0;
    receiver_steady <= 1'b0;
    for (int k = 0; k < 8; k++) send_sample({x_steps[k], 32'd0, $urandom, 16'($urandom)});
  endtask

  // Stillness search under several settings. Most words extend a still run,
  // the rest are noise and deliberate breaks; a word that would end the
  // search is swapped for a break so that averaging is saved for later.
  task automatic test_still_runs();
    int pick;
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: set_calibration_registers(16'd1, 8'd255, 16'sh8000);
        1: set_calibration_registers(16'h8000, 8'd1, 16'sh7FFF);
        default: set_calibration_registers(16'($urandom_range(2, 32768)),
                                           8'($urandom_range(2, 255)), 16'($urandom));
      endcase
      sender_steady = (seg % 3 == 0);
      receiver_steady <= (seg % 3 == 1);
      // In this segment the receiver backs off for a long stretch while
      // the sender keeps offering words back to back.
      if (seg == 2) begin
        sender_steady = 1'b1;
        hold_requests <= hold_requests + 1;
      end
      repeat (70) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) send_sample(keep_waiting(make_sample(SAMPLE_STILL)));
        else if (pick < 17) send_sample(keep_waiting(make_sample(SAMPLE_NOISE)));
        else send_sample(make_sample(SAMPLE_BREAK));
      end
    end
  endtask

  // Full calibration: a zero run length lets the first still word start
  // averaging, the most negative gravity pushes the z sum toward wrapping,
  // and afterwards every word must come back minus the new offsets. Writes
  // in the calibrated phase must leave the offsets unchanged.
  task automatic test_calibration();
    set_calibration_registers(16'd1, 8'd0, 16'sh8000);
    for (int i = 0; i < AXES; i++) rest_base[i] = $signed(16'($urandom));
    sender_steady = 1'b0;
    receiver_steady <= 1'b0;
    while (cal_phase == PH_WAIT_STILL) send_sample(make_sample(SAMPLE_STILL));
    while (cal_phase == PH_AVERAGING)
      send_sample(make_sample(($urandom_range(0, 2) == 0) ? SAMPLE_NOISE : SAMPLE_REST));
    repeat (180) send_sample(make_sample(SAMPLE_NOISE));
    set_calibration_registers(16'hFFFF, 8'd255, 16'sh7FFF);
    write_register(CFG_UNMAPPED, $urandom);
    sender_steady = 1'b1;
    receiver_steady <= 1'b1;
    hold_requests <= hold_requests + 1;
    repeat (60) send_sample(make_sample(SAMPLE_NOISE));
    sender_steady = 1'b0;
    receiver_steady <= 1'b0;
    repeat (120) send_sample(make_sample(SAMPLE_NOISE));
  endtask

  initial begin : test_sequence
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_defaults();
    test_zero_threshold();
    test_widest_threshold();
    test_still_runs();
    test_calibration();
    wait_drained();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
